@@ hw/rtl/stkpf_pkg.sv @@
package stkpf_pkg;

    localparam int AMP_W   = 16;
    localparam int BIN_W   = 16;
    localparam int HZ_W    = 32;
    localparam int FREQ_W  = 48;
    localparam int RANK_W  = 6;
    localparam int NPK_W   = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NUM_PEAKS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HZ_PER_BIN = 1'b1;

    // Amplitude reported for a slot that never received a bin
    localparam logic signed [AMP_W-1:0] EMPTY_AMP = 16'sh8000;

    localparam logic [NPK_W-1:0] NUM_PEAKS_RESET  = 7'd1;
    localparam logic [HZ_W-1:0]  HZ_PER_BIN_RESET = 32'd1;

    typedef struct packed {
        logic                    valid;
        logic signed [AMP_W-1:0] amp;
        logic [BIN_W-1:0]        bin;
    } slot_t;

    typedef struct packed {
        logic insert;     // place the incoming bin
        logic shift_out;  // move every slot one place toward the head
        logic clear;      // drop every slot
    } chain_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_ERROR
    } state_t;

endpackage

@@ hw/rtl/spectrum_top_k_peak_finder_core.sv @@
// Top-k spectrum peak finder: sorted insertion chain, one cell per kept peak.
// Throughput: one bin per cycle while a frame streams in; every cell compares
// the bin with its own entry and takes its left neighbor's entry in the same cycle.
// Output: the last bin sets the state register, then results are registered one per
// cycle while peak_stall is low (num_peaks or one error result); input stalled.
// Reset: all slots empty, bin count zero, num_peaks = 1, hz_per_bin = 1.
module spectrum_top_k_peak_finder_core
    import stkpf_pkg::*;
#(
    parameter int MAX_PEAKS = 64,
    parameter int MAX_BINS  = 65536
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    // bin requests
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  logic signed [AMP_W-1:0]  amplitude,
    input  logic                     last_sample,
    // peak results
    output logic                     peak_valid,
    input  logic                     peak_stall,
    output logic [RANK_W-1:0]        rank,
    output logic signed [AMP_W-1:0]  peak_amplitude,
    output logic [BIN_W-1:0]         peak_bin,
    output logic [FREQ_W-1:0]        frequency_offset,
    output logic                     status,
    output logic                     last_result
);

    localparam int CNT_W = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BINS - 1);

    // Configuration registers; the user must write only while the block is idle,
    // which the block itself does not enforce; the port never pushes back.
    logic [NPK_W-1:0] num_peaks_reg;
    logic [HZ_W-1:0]  hz_per_bin_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_peaks_reg  <= NUM_PEAKS_RESET;
            hz_per_bin_reg <= HZ_PER_BIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NUM_PEAKS:  num_peaks_reg  <= cfg_data[NPK_W-1:0];
                REG_HZ_PER_BIN: hz_per_bin_reg <= cfg_data[HZ_W-1:0];
                default:        ;
            endcase
        end
    end

    // Clamp the peak count into 1..MAX_PEAKS
    logic [NPK_W-1:0] active_peaks;

    always_comb
    begin
        if (num_peaks_reg == '0)
            active_peaks = NPK_W'(1);
        else if (num_peaks_reg > NPK_W'(MAX_PEAKS))
            active_peaks = NPK_W'(MAX_PEAKS);
        else
            active_peaks = num_peaks_reg;
    end

    // Control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  bin_count_reg, bin_count_next;
    logic [RANK_W-1:0] rank_reg, rank_next;

    // Output register and its payload
    logic                    out_valid_reg, out_valid_next;
    logic [RANK_W-1:0]       out_rank_reg, out_rank_next;
    logic signed [AMP_W-1:0] out_amp_reg, out_amp_next;
    logic [BIN_W-1:0]        out_bin_reg, out_bin_next;
    logic [FREQ_W-1:0]       out_freq_reg, out_freq_next;
    logic                    out_status_reg, out_status_next;
    logic                    out_last_reg, out_last_next;

    chain_ctrl_t ctrl;
    slot_t       new_item;
    slot_t       head;
    logic        sample_accept;
    logic        out_load;
    logic        too_few;
    logic        final_rank;

    // Hold off bins while results of the finished frame go out
    assign sample_stall  = (state_reg != ST_IDLE);
    assign sample_accept = sample_valid && !sample_stall;
    assign out_load      = !out_valid_reg || !peak_stall;

    // The frame is short if the last bin's index plus one is below the count
    assign too_few    = ({1'b0, bin_count_reg} + (CNT_W + 1)'(1)) < (CNT_W + 1)'(active_peaks);
    assign final_rank = ({1'b0, rank_reg} == (active_peaks - NPK_W'(1)));

    assign new_item = '{valid: 1'b1, amp: amplitude, bin: BIN_W'(bin_count_reg)};

    stkpf_chain #(
        .MAX_PEAKS (MAX_PEAKS)
    ) u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .active_peaks (active_peaks),
        .new_item     (new_item),
        .head         (head)
    );

    always_comb
    begin
        state_next      = state_reg;
        bin_count_next  = bin_count_reg;
        rank_next       = rank_reg;
        ctrl            = '0;
        out_valid_next  = out_valid_reg;
        out_rank_next   = out_rank_reg;
        out_amp_next    = out_amp_reg;
        out_bin_next    = out_bin_reg;
        out_freq_next   = out_freq_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        // drop a taken result; the states below refill the register
        if (out_load)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_accept)
                begin
                    ctrl.insert = 1'b1;
                    rank_next   = '0;
                    if (last_sample)
                    begin
                        bin_count_next = '0;
                        state_next     = too_few ? ST_ERROR : ST_DRAIN;
                    end
                    else if (bin_count_reg < CNT_MAX)
                    begin
                        bin_count_next = bin_count_reg + CNT_W'(1);
                    end
                end
            end

            ST_DRAIN:
            begin
                if (out_load)
                begin
                    // report the head slot, then advance the chain toward it or clear it at the end
                    out_valid_next  = 1'b1;
                    out_rank_next   = rank_reg;
                    out_status_next = 1'b0;
                    out_last_next   = final_rank;
                    if (head.valid)
                    begin
                        out_amp_next  = head.amp;
                        out_bin_next  = head.bin;
                        out_freq_next = FREQ_W'(hz_per_bin_reg) * FREQ_W'(head.bin);
                    end
                    else
                    begin
                        out_amp_next  = EMPTY_AMP;
                        out_bin_next  = '0;
                        out_freq_next = '0;
                    end
                    rank_next = rank_reg + RANK_W'(1);
                    if (final_rank)
                    begin
                        ctrl.clear = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ctrl.shift_out = 1'b1;
                    end
                end
            end

            ST_ERROR:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_rank_next   = '0;
                    out_amp_next    = '0;
                    out_bin_next    = '0;
                    out_freq_next   = '0;
                    out_status_next = 1'b1;
                    out_last_next   = 1'b1;
                    ctrl.clear      = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bin_count_reg <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bin_count_reg <= bin_count_next;
            rank_reg      <= rank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rank_reg   <= out_rank_next;
        out_amp_reg    <= out_amp_next;
        out_bin_reg    <= out_bin_next;
        out_freq_reg   <= out_freq_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign peak_valid       = out_valid_reg;
    assign rank             = out_rank_reg;
    assign peak_amplitude   = out_amp_reg;
    assign peak_bin         = out_bin_reg;
    assign frequency_offset = out_freq_reg;
    assign status           = out_status_reg;
    assign last_result      = out_last_reg;

    // An error result always closes its frame
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (peak_valid && status) |-> last_result)
        else $error("error result without last_result");

    // A closing bin starts the report
    a_last_starts_report: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall && last_sample) |=> (state_reg != ST_IDLE))
        else $error("last bin did not start a report");

    // Results of one frame follow each other with consecutive ranks
    a_rank_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (peak_valid && !peak_stall && !last_result)
        |=> (peak_valid && (rank == RANK_W'($past(rank) + RANK_W'(1)))))
        else $error("rank sequence broken");

endmodule

@@ hw/rtl/stkpf_cell.sv @@
module stkpf_cell
    import stkpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  chain_ctrl_t ctrl,
    input  logic        active,
    input  slot_t       new_item,
    input  logic        left_beats,
    input  slot_t       left_slot,
    input  slot_t       right_slot,
    output logic        beats,
    output slot_t       slot
);

    logic                    valid_reg, valid_next;
    logic signed [AMP_W-1:0] amp_reg, amp_next;
    logic [BIN_W-1:0]        bin_reg, bin_next;

    // The incoming bin wins this slot if the slot is empty or strictly weaker
    assign beats = active && (!valid_reg || (new_item.amp > amp_reg));

    always_comb
    begin
        valid_next = valid_reg;
        amp_next   = amp_reg;
        bin_next   = bin_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift_out)
        begin
            valid_next = right_slot.valid;
            amp_next   = right_slot.amp;
            bin_next   = right_slot.bin;
        end
        else if (ctrl.insert && beats)
        begin
            // take the neighbor's entry if it moved down, else the new bin
            if (left_beats)
            begin
                valid_next = left_slot.valid;
                amp_next   = left_slot.amp;
                bin_next   = left_slot.bin;
            end
            else
            begin
                valid_next = 1'b1;
                amp_next   = new_item.amp;
                bin_next   = new_item.bin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amp_reg <= amp_next;
        bin_reg <= bin_next;
    end

    assign slot = '{valid: valid_reg, amp: amp_reg, bin: bin_reg};

endmodule

@@ hw/rtl/stkpf_chain.sv @@
module stkpf_chain
    import stkpf_pkg::*;
#(
    parameter int MAX_PEAKS = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  chain_ctrl_t      ctrl,
    input  logic [NPK_W-1:0] active_peaks,
    input  slot_t            new_item,
    output slot_t            head
);

    slot_t slot_q [MAX_PEAKS];
    logic  beats  [MAX_PEAKS];

    for (genvar j = 0; j < MAX_PEAKS; j++)
    begin : g_cell
        logic  left_beats;
        slot_t left_slot;
        slot_t right_slot;

        if (j == 0)
        begin : g_head
            assign left_beats = 1'b0;
            assign left_slot  = new_item;
        end
        else
        begin : g_body
            assign left_beats = beats[j-1];
            assign left_slot  = slot_q[j-1];
        end

        if (j == MAX_PEAKS - 1)
        begin : g_tail
            assign right_slot = '0;
        end
        else
        begin : g_inner
            assign right_slot = slot_q[j+1];
        end

        stkpf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .active     (NPK_W'(j) < active_peaks),
            .new_item   (new_item),
            .left_beats (left_beats),
            .left_slot  (left_slot),
            .right_slot (right_slot),
            .beats      (beats[j]),
            .slot       (slot_q[j])
        );
    end

    assign head = slot_q[0];

endmodule
